FILE: src/ccx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccx_pkg
// Shared types, constants and round helpers for the keystream XOR block.
// ----------------------------------------------------------------------------
package ccx_pkg;

  localparam int BLOCK_BYTES_DEF = 64;
  localparam int CFG_COUNT = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START   = 3'd5;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  localparam int DOUBLE_ROUNDS = 10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_out;
  } out_item_t;

  typedef logic [15:0][31:0] words_t;

  typedef enum logic [1:0] {
    GEN_IDLE,
    GEN_COL,
    GEN_DIAG,
    GEN_ADD
  } gen_state_t;

  // One quarter round on four words; returns {a,b,c,d}.
  function automatic logic [127:0] quarter(input logic [31:0] a0, input logic [31:0] b0,
                                           input logic [31:0] c0, input logic [31:0] d0);
    logic [31:0] a, b, c, d;
    begin
      a = a0; b = b0; c = c0; d = d0;
      a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
      c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
      a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
      c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
      quarter = {a, b, c, d};
    end
  endfunction

endpackage
`default_nettype wire

FILE: src/ccx_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccx_front
// Input queue between the push side and the keystream back end.
// ----------------------------------------------------------------------------
module ccx_front import ccx_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire in_item_t in_item,
  output logic          full,
  output logic          avail,
  output in_item_t      head,
  input  wire logic     take
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  in_item_t         slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [PW:0]      count;
  logic             do_push;
  logic             do_take;

  assign full    = (count == (PW+1)'(DEPTH));
  assign avail   = (count != '0);
  assign head    = slots[rptr];
  assign do_push = push && !full;
  assign do_take = take && avail;

  // Store pushed items
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= in_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_take) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (PW+1)'(do_push) - (PW+1)'(do_take);
    end
  end

endmodule
`default_nettype wire

FILE: src/ccx_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccx_core
// Block generator: one column or diagonal round per cycle, then feed-forward.
// ----------------------------------------------------------------------------
module ccx_core import ccx_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire words_t   init,
  output logic          busy,
  output logic          done,
  output words_t        block
);

  gen_state_t  state, state_next;
  words_t      work, work_next;
  words_t      base;
  logic [3:0]  rnd, rnd_next;
  logic [127:0] q0, q1, q2, q3;

  // Round arithmetic for the current phase
  always_comb begin
    work_next = work;
    q0 = '0; q1 = '0; q2 = '0; q3 = '0;
    if (state == GEN_COL) begin
      q0 = quarter(work[0], work[4], work[8],  work[12]);
      q1 = quarter(work[1], work[5], work[9],  work[13]);
      q2 = quarter(work[2], work[6], work[10], work[14]);
      q3 = quarter(work[3], work[7], work[11], work[15]);
      {work_next[0], work_next[4], work_next[8],  work_next[12]} = q0;
      {work_next[1], work_next[5], work_next[9],  work_next[13]} = q1;
      {work_next[2], work_next[6], work_next[10], work_next[14]} = q2;
      {work_next[3], work_next[7], work_next[11], work_next[15]} = q3;
    end else if (state == GEN_DIAG) begin
      q0 = quarter(work[0], work[5], work[10], work[15]);
      q1 = quarter(work[1], work[6], work[11], work[12]);
      q2 = quarter(work[2], work[7], work[8],  work[13]);
      q3 = quarter(work[3], work[4], work[9],  work[14]);
      {work_next[0], work_next[5], work_next[10], work_next[15]} = q0;
      {work_next[1], work_next[6], work_next[11], work_next[12]} = q1;
      {work_next[2], work_next[7], work_next[8],  work_next[13]} = q2;
      {work_next[3], work_next[4], work_next[9],  work_next[14]} = q3;
    end else if (state == GEN_ADD) begin
      for (int i = 0; i < 16; i++) begin
        work_next[i] = work[i] + base[i];
      end
    end
  end

  // Sequence the rounds
  always_comb begin
    state_next = state;
    rnd_next   = rnd;
    done       = 1'b0;
    case (state)
      GEN_IDLE: begin
        if (start) begin
          state_next = GEN_COL;
          rnd_next   = '0;
        end
      end
      GEN_COL: state_next = GEN_DIAG;
      GEN_DIAG: begin
        rnd_next = rnd + 1'b1;
        state_next = (rnd == 4'(DOUBLE_ROUNDS - 1)) ? GEN_ADD : GEN_COL;
      end
      GEN_ADD: begin
        state_next = GEN_IDLE;
        done       = 1'b1;
      end
      default: state_next = GEN_IDLE;
    endcase
  end

  assign busy  = (state != GEN_IDLE);
  assign block = work_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= GEN_IDLE;
      rnd   <= '0;
    end else begin
      state <= state_next;
      rnd   <= rnd_next;
    end
  end

  // Load or advance the working words
  always_ff @(posedge clk) begin
    if (state == GEN_IDLE && start) begin
      work <= init;
      base <= init;
    end else if (state == GEN_COL || state == GEN_DIAG) begin
      work <= work_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/ccx_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccx_back
// Keystream buffer, read position, counter, and the output register.
// ----------------------------------------------------------------------------
module ccx_back import ccx_pkg::*; #(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]        cfg_data,
  input  wire logic               avail,
  input  wire in_item_t           head,
  output logic                    take,
  output logic                    empty,
  output out_item_t               result,
  input  wire logic               pop
);

  localparam int PW = $clog2(BLOCK_BYTES);

  logic [63:0]  cfg_regs [CFG_COUNT];
  logic [63:0]  counter;
  logic [PW:0]  pos;
  logic [31:0]  ks [BLOCK_BYTES/4];
  logic         gen_start, gen_busy, gen_done;
  words_t       init, block;
  logic         out_valid;
  logic         exhausted;
  logic         cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(CFG_COUNT));
  assign exhausted = pos[PW];
  assign gen_start = avail && exhausted && !gen_busy && !cfg_fire;
  assign take      = avail && !exhausted && (!out_valid || pop) && !cfg_fire;
  assign empty     = !out_valid;

  // Assemble the block input words
  always_comb begin
    init[0] = SIGMA0; init[1] = SIGMA1; init[2] = SIGMA2; init[3] = SIGMA3;
    for (int i = 0; i < 4; i++) begin
      init[4 + 2*i] = cfg_regs[i][31:0];
      init[5 + 2*i] = cfg_regs[i][63:32];
    end
    init[12] = counter[31:0];
    init[13] = counter[63:32];
    init[14] = cfg_regs[CFG_NONCE][31:0];
    init[15] = cfg_regs[CFG_NONCE][63:32];
  end

  ccx_core u_core (
    .clk   (clk),
    .rst   (rst),
    .start (gen_start),
    .init  (init),
    .busy  (gen_busy),
    .done  (gen_done),
    .block (block)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CFG_COUNT; i++) cfg_regs[i] <= '0;
    end else if (cfg_fire) begin
      cfg_regs[cfg_index] <= cfg_data;
    end
  end

  // Refill the keystream buffer, one little-endian word per entry
  always_ff @(posedge clk) begin
    if (gen_done) begin
      for (int i = 0; i < 16; i++) begin
        ks[i] <= block[i];
      end
    end
  end

  // Track position and counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= (PW+1)'(BLOCK_BYTES);
      counter <= '0;
    end else if (cfg_fire) begin
      pos     <= (PW+1)'(BLOCK_BYTES);
      counter <= (cfg_index == CFG_START) ? cfg_data : cfg_regs[CFG_START];
    end else if (gen_done) begin
      pos     <= '0;
      counter <= counter + 64'd1;
    end else if (take) begin
      pos <= pos + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.out_byte <= head.data_byte ^ ks[pos[PW-1:2]][8*pos[1:0] +: 8];
      result.last_out <= head.last_in;
    end
  end

endmodule
`default_nettype wire

FILE: src/chacha20_keystream_xor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chacha20_keystream_xor
// Byte-serial ChaCha20 keystream combiner (encrypt and decrypt alike).
// ----------------------------------------------------------------------------
// Path: a pushed byte passes the input queue slot and the output register;
// the first byte of each block also waits for the block generator (its
// start, the column and diagonal rounds, then the feed-forward step).
// Throughput: one byte per cycle inside a block while results are popped.
// Reset: key, nonce and counter clear to zero, keystream marked used up.
module chacha20_keystream_xor import ccx_pkg::*; #(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire in_item_t             in_item,
  output logic                      empty,
  input  wire logic                 pop,
  output out_item_t                 out_item,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data
);

  logic     avail;
  logic     take;
  in_item_t head;

  ccx_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .in_item (in_item),
    .full    (full),
    .avail   (avail),
    .head    (head),
    .take    (take)
  );

  ccx_back #(.BLOCK_BYTES(BLOCK_BYTES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .avail     (avail),
    .head      (head),
    .take      (take),
    .empty     (empty),
    .result    (out_item),
    .pop       (pop)
  );

endmodule
`default_nettype wire

FILE: src/ccx_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccx_checker
// Port-level checks for the keystream combiner, bound to the top level.
// ----------------------------------------------------------------------------
module ccx_checker import ccx_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      full,
  input wire logic      empty,
  input wire logic      pop,
  input wire out_item_t out_item,
  input wire logic      cfg_ready
);

  // Held result keeps its value until transfer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(out_item))
    else $error("result changed while waiting");

  // Nothing is waiting right after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result present after reset");

  // Queue is not full right after reset
  a_rst_full: assert property (@(posedge clk) rst |=> !full)
    else $error("input full after reset");

  // Configuration always ready
  a_cfg: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port stalled");

endmodule

bind chacha20_keystream_xor ccx_checker u_ccx_checker (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .out_item  (out_item),
  .cfg_ready (cfg_ready)
);
`default_nettype wire
